/* hw/rtl/arw_pkg.sv */
// Shared types, constants and a mask helper for the anti-replay window block.
`default_nettype none
package arw_pkg;

	// Window and field sizes
	localparam int MAX_WINDOW = 64;
	localparam int SEQ_W      = 64;
	localparam int LOW_W      = 32;
	localparam int WIDTH_W    = 7;
	localparam int BIT_IDX_W  = $clog2(MAX_WINDOW);
	localparam int STATUS_W   = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COMMIT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTORE = 2'd2;

	// Check status codes
	localparam logic [STATUS_W-1:0] ST_ADMISSIBLE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_OLD    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_SEQ   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_MODE = 8'd1;

	// Reset value of the window width register
	localparam logic [WIDTH_W-1:0] WINDOW_RESET = WIDTH_W'(MAX_WINDOW);

	// Window state: bit d of the bitmap marks highest - d
	typedef struct packed {
		logic [SEQ_W-1:0] highest;
		logic [SEQ_W-1:0] bitmap;
	} win_state_t;

	// Mask of the low w bits of the bitmap
	function automatic logic [SEQ_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
		logic [SEQ_W-1:0] m;
		begin
			if (w == '0)
				m = '0;
			else if (w >= WIDTH_W'(SEQ_W))
				m = '1;
			else
				m = (SEQ_W'(1) << w[BIT_IDX_W-1:0]) - SEQ_W'(1);
			return m;
		end
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/arw_if.sv */
// Channel interfaces of the anti-replay window block.
`default_nettype none
interface arw_in_if;
	logic                               valid;
	logic                               ready;
	logic [arw_pkg::MODE_W-1:0]         mode;
	logic [arw_pkg::LOW_W-1:0]          rx_low;
	logic [arw_pkg::SEQ_W-1:0]          auth_seq;
	logic [arw_pkg::SEQ_W-1:0]          restore_highest;
	logic [arw_pkg::SEQ_W-1:0]          restore_bitmap;

	modport source (output valid, mode, rx_low, auth_seq,
		restore_highest, restore_bitmap, input ready);
	modport sink (input valid, mode, rx_low, auth_seq,
		restore_highest, restore_bitmap, output ready);
endinterface

interface arw_out_if;
	logic                               valid;
	logic                               ready;
	logic [arw_pkg::STATUS_W-1:0]       status;
	logic [arw_pkg::SEQ_W-1:0]          full_sequence;
	logic                               accepted;

	modport source (output valid, status, full_sequence, accepted, input ready);
	modport sink (input valid, status, full_sequence, accepted, output ready);
endinterface

interface arw_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [arw_pkg::CFG_IDX_W-1:0]      index;
	logic [arw_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ipsec_antireplay_window_esn_top.sv */
// Top level of the IPsec anti-replay window with extended sequence numbers.
// Throughput: one word per cycle while out_ch is ready. The input register and the
// result register each hold one word; a word's result is driven on out_ch from the
// result register, and the window state is updated as a word moves into it.
// Reset clears the window state and both stage valids, and sets width 64, extended mode off.
// Configuration writes are taken in every cycle.
`default_nettype none
module ipsec_antireplay_window_esn_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	arw_cfg_if.sink    cfg_ch,
	arw_in_if.sink     in_ch,
	arw_out_if.source  out_ch
);

	// Configuration
	logic [arw_pkg::WIDTH_W-1:0]  window_width_q;
	logic                         extended_mode_q;
	logic [arw_pkg::WIDTH_W-1:0]  eff_width;

	// Window state
	arw_pkg::win_state_t          win_q;
	arw_pkg::win_state_t          win_next;

	// Input register
	logic                         valid_s1;
	logic [arw_pkg::MODE_W-1:0]   mode_s1;
	logic [arw_pkg::LOW_W-1:0]    rx_low_s1;
	logic [arw_pkg::SEQ_W-1:0]    auth_seq_s1;
	logic [arw_pkg::SEQ_W-1:0]    restore_highest_s1;
	logic [arw_pkg::SEQ_W-1:0]    restore_bitmap_s1;

	// Result register
	logic                         out_valid_q;
	logic [arw_pkg::STATUS_W-1:0] status_q;
	logic [arw_pkg::SEQ_W-1:0]    full_sequence_q;
	logic                         accepted_q;

	logic                         in_accept;
	logic                         advance;
	logic [arw_pkg::STATUS_W-1:0] chk_status;
	logic [arw_pkg::SEQ_W-1:0]    chk_full;
	logic                         upd_accepted;

	assign cfg_ch.ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q  <= arw_pkg::WINDOW_RESET;
			extended_mode_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				arw_pkg::CFG_WINDOW_WIDTH:  window_width_q  <= cfg_ch.data[arw_pkg::WIDTH_W-1:0];
				arw_pkg::CFG_EXTENDED_MODE: extended_mode_q <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	// Oversized width disables the window
	assign eff_width = (window_width_q > arw_pkg::WIDTH_W'(arw_pkg::MAX_WINDOW)) ?
		'0 : window_width_q;

	// Handshake
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_accept   = in_ch.valid && in_ch.ready;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1            <= in_ch.mode;
			rx_low_s1          <= in_ch.rx_low;
			auth_seq_s1        <= in_ch.auth_seq;
			restore_highest_s1 <= in_ch.restore_highest;
			restore_bitmap_s1  <= in_ch.restore_bitmap;
		end
	end

	arw_check u_check (
		.rx_low        (rx_low_s1),
		.st            (win_q),
		.width         (eff_width),
		.extended      (extended_mode_q),
		.status        (chk_status),
		.full_sequence (chk_full)
	);

	arw_update u_update (
		.mode            (mode_s1),
		.auth_seq        (auth_seq_s1),
		.restore_highest (restore_highest_s1),
		.restore_bitmap  (restore_bitmap_s1),
		.st              (win_q),
		.width           (eff_width),
		.extended        (extended_mode_q),
		.st_next         (win_next),
		.accepted        (upd_accepted)
	);

	// Advance the window state with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= win_next;
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q        <= (mode_s1 == arw_pkg::MODE_CHECK) ? chk_status : '0;
			full_sequence_q <= (mode_s1 == arw_pkg::MODE_CHECK) ? chk_full : '0;
			accepted_q      <= upd_accepted;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.full_sequence = full_sequence_q;
	assign out_ch.accepted      = accepted_q;

	// Empty highest and empty bitmap go together
	a_state_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(win_q.highest == '0) == (win_q.bitmap == '0))
		else $error("window highest and bitmap disagree on emptiness");

	// A non-empty window always marks its highest
	a_state_top: assert property (@(posedge clk) disable iff (!arst_n)
		(win_q.highest != '0) |-> win_q.bitmap[0])
		else $error("highest not marked in bitmap");

	// State moves only with a word
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(win_q))
		else $error("window state changed without a word");

	// An empty result register never stalls the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty result register");

	// Non-check words report zero status and sequence
	a_noncheck_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1 != arw_pkg::MODE_CHECK) |=> (status_q == '0 && full_sequence_q == '0))
		else $error("status or sequence set outside check mode");

endmodule
`default_nettype wire

/* hw/rtl/arw_check.sv */
// Check path: rebuilds the full sequence number and classifies it against the window.
`default_nettype none
module arw_check (
	input  wire logic [arw_pkg::LOW_W-1:0]    rx_low,
	input  wire arw_pkg::win_state_t          st,
	input  wire logic [arw_pkg::WIDTH_W-1:0]  width,
	input  wire logic                         extended,
	output logic [arw_pkg::STATUS_W-1:0]      status,
	output logic [arw_pkg::SEQ_W-1:0]         full_sequence
);

	logic [arw_pkg::LOW_W-1:0]   top_low;
	logic [arw_pkg::LOW_W-1:0]   top_high;
	logic [arw_pkg::LOW_W-1:0]   lag;
	logic [arw_pkg::LOW_W-1:0]   floor_prev;
	logic [arw_pkg::LOW_W-1:0]   floor_next;
	logic [arw_pkg::LOW_W-1:0]   high_sel;
	logic                        rebuilt;
	logic [arw_pkg::SEQ_W-1:0]   seq;
	logic [arw_pkg::SEQ_W-1:0]   offset;

	assign top_low    = st.highest[arw_pkg::LOW_W-1:0];
	assign top_high   = st.highest[arw_pkg::SEQ_W-1:arw_pkg::LOW_W];
	assign lag        = arw_pkg::LOW_W'(width) - arw_pkg::LOW_W'(1);
	// Lowest low word that still belongs to the previous epoch
	assign floor_prev = arw_pkg::LOW_W'(0) - (lag - top_low);
	assign floor_next = top_low - lag;

	// Rebuild the high word from the window position
	always_comb begin
		rebuilt  = 1'b1;
		high_sel = '0;
		if (width == '0) begin
			rebuilt = 1'b0;
		end else if (!extended || st.highest == '0) begin
			rebuilt = (rx_low != '0);
		end else if (top_low < lag) begin
			high_sel = top_high;
			if (rx_low >= floor_prev) begin
				if (top_high == '0)
					rebuilt = 1'b0;
				else
					high_sel = top_high - arw_pkg::LOW_W'(1);
			end
		end else begin
			high_sel = top_high;
			if (rx_low < floor_next) begin
				if (top_high == '1)
					rebuilt = 1'b0;
				else
					high_sel = top_high + arw_pkg::LOW_W'(1);
			end
		end
	end

	assign seq    = {high_sel, rx_low};
	assign offset = st.highest - seq;

	// Classify against the window
	always_comb begin
		full_sequence = '0;
		if (width == '0) begin
			status = arw_pkg::ST_INVALID;
		end else if (!rebuilt) begin
			status = (rx_low == '0) ? arw_pkg::ST_ZERO_SEQ : arw_pkg::ST_EXHAUSTED;
		end else begin
			full_sequence = seq;
			if (st.highest == '0 || seq > st.highest)
				status = arw_pkg::ST_ADMISSIBLE;
			else if (offset >= arw_pkg::SEQ_W'(width))
				status = arw_pkg::ST_TOO_OLD;
			else if (st.bitmap[offset[arw_pkg::BIT_IDX_W-1:0]])
				status = arw_pkg::ST_DUPLICATE;
			else
				status = arw_pkg::ST_ADMISSIBLE;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/arw_update.sv */
// Commit and restore path: next window state and acceptance.
`default_nettype none
module arw_update (
	input  wire logic [arw_pkg::MODE_W-1:0]   mode,
	input  wire logic [arw_pkg::SEQ_W-1:0]    auth_seq,
	input  wire logic [arw_pkg::SEQ_W-1:0]    restore_highest,
	input  wire logic [arw_pkg::SEQ_W-1:0]    restore_bitmap,
	input  wire arw_pkg::win_state_t          st,
	input  wire logic [arw_pkg::WIDTH_W-1:0]  width,
	input  wire logic                         extended,
	output arw_pkg::win_state_t               st_next,
	output logic                              accepted
);

	logic [arw_pkg::SEQ_W-1:0] mask;
	logic [arw_pkg::SEQ_W-1:0] seq;
	logic [arw_pkg::SEQ_W-1:0] adv;
	logic [arw_pkg::SEQ_W-1:0] offset;
	logic [arw_pkg::SEQ_W-1:0] slid;
	logic                      seq_bad;
	logic                      rst_bad;

	assign mask   = arw_pkg::width_mask(width);
	assign seq    = auth_seq;
	assign adv    = seq - st.highest;
	assign offset = st.highest - seq;

	// Slide the bitmap forward and mark the new highest
	assign slid = (adv >= arw_pkg::SEQ_W'(width)) ? arw_pkg::SEQ_W'(1) :
		((st.bitmap << adv[arw_pkg::BIT_IDX_W-1:0]) | arw_pkg::SEQ_W'(1));

	assign seq_bad = (width == '0) || (seq == '0) ||
		(!extended && seq[arw_pkg::SEQ_W-1:arw_pkg::LOW_W] != '0);

	assign rst_bad = (width == '0) ||
		(!extended && restore_highest[arw_pkg::SEQ_W-1:arw_pkg::LOW_W] != '0) ||
		((restore_bitmap & ~mask) != '0) ||
		((restore_highest == '0) != (restore_bitmap == '0)) ||
		(restore_highest != '0 && !restore_bitmap[0]);

	always_comb begin
		st_next  = st;
		accepted = 1'b0;
		case (mode)
			arw_pkg::MODE_COMMIT: begin
				if (!seq_bad) begin
					if (st.highest == '0) begin
						st_next.highest = seq;
						st_next.bitmap  = arw_pkg::SEQ_W'(1);
						accepted        = 1'b1;
					end else if (seq > st.highest) begin
						st_next.highest = seq;
						st_next.bitmap  = slid & mask;
						accepted        = 1'b1;
					end else if (offset < arw_pkg::SEQ_W'(width) &&
							!st.bitmap[offset[arw_pkg::BIT_IDX_W-1:0]]) begin
						st_next.bitmap = st.bitmap |
							(arw_pkg::SEQ_W'(1) << offset[arw_pkg::BIT_IDX_W-1:0]);
						accepted       = 1'b1;
					end
				end
			end
			arw_pkg::MODE_RESTORE: begin
				if (!rst_bad) begin
					st_next.highest = restore_highest;
					st_next.bitmap  = restore_bitmap;
					accepted        = 1'b1;
				end
			end
			default: begin
				accepted = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the IPsec anti-replay window with extended sequence numbers.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [arw_pkg::MODE_W-1:0]    MODE_UNUSED  = 2'd3;
	localparam logic [arw_pkg::CFG_IDX_W-1:0] CFG_UNUSED   = 8'd2;
	localparam int                            HOLD_CYCLES  = 300;
	localparam int                            DRAIN_CYCLES = 10;
	localparam int                            CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [arw_pkg::MODE_W-1:0] mode;
		logic [arw_pkg::LOW_W-1:0]  rx_low;
		logic [arw_pkg::SEQ_W-1:0]  auth_seq;
		logic [arw_pkg::SEQ_W-1:0]  restore_highest;
		logic [arw_pkg::SEQ_W-1:0]  restore_bitmap;
	} replay_item_t;

	typedef struct packed {
		logic [arw_pkg::STATUS_W-1:0] status;
		logic [arw_pkg::SEQ_W-1:0]    full_sequence;
		logic                         accepted;
	} verdict_t;

	logic clk;
	logic arst_n;

	arw_cfg_if cfg_ch ();
	arw_in_if  in_ch ();
	arw_out_if out_ch ();

	ipsec_antireplay_window_esn_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Predictor copy of the registers and the window
	logic [arw_pkg::WIDTH_W-1:0] cfg_width   = arw_pkg::WINDOW_RESET;
	logic                        cfg_ext     = 1'b0;
	logic [arw_pkg::SEQ_W-1:0]   win_highest = '0;
	logic [arw_pkg::SEQ_W-1:0]   win_bitmap  = '0;

	replay_item_t pending_items[$];
	verdict_t     predicted_verdicts[$];
	replay_item_t offered;
	verdict_t     want;

	int mismatches  = 0;
	int cycle_count = 0;
	int burst_left  = 1;
	int gap_left    = 0;
	int hold_token  = 0;
	int hold_seen   = 0;
	int hold_left   = 0;
	int pattern_age = 0;
	logic [15:0] stall_pattern = '1;

	// Free-running clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Ones in the low w bits
	function automatic logic [arw_pkg::SEQ_W-1:0] low_ones(input logic [arw_pkg::SEQ_W-1:0] w);
		if (w == 0)
			return '0;
		if (w >= 64)
			return '1;
		return (64'd1 << w[5:0]) - 64'd1;
	endfunction

	// Work out the verdict of one word and move the window as the block would
	function automatic verdict_t advance_window(input replay_item_t it);
		verdict_t                  r;
		logic [arw_pkg::SEQ_W-1:0] w, seq, offset, adv;
		logic [31:0]               top_low, top_high, lag, floor_prev;
		bit                        ok;
		r = '0;
		w = (cfg_width > arw_pkg::WIDTH_W'(arw_pkg::MAX_WINDOW)) ? 64'd0 : 64'(cfg_width);
		case (it.mode)
		arw_pkg::MODE_CHECK: begin
			ok = 1'b1;
			seq = 64'(it.rx_low);
			if (w == 0) begin
				r.status = arw_pkg::ST_INVALID;
			end else begin
				if (it.rx_low == 0 && (!cfg_ext || win_highest == 0)) begin
					ok = 1'b0;
				end else if (cfg_ext && win_highest != 0) begin
					// Rebuild the high word from where the window sits
					top_low  = win_highest[31:0];
					top_high = win_highest[63:32];
					lag      = w[31:0] - 32'd1;
					if (top_low < lag) begin
						floor_prev = 32'hFFFF_FFFF - (lag - top_low) + 32'd1;
						if (it.rx_low >= floor_prev) begin
							if (top_high == 0)
								ok = 1'b0;
							else
								top_high = top_high - 32'd1;
						end
					end else if (it.rx_low < top_low - lag) begin
						if (top_high == 32'hFFFF_FFFF)
							ok = 1'b0;
						else
							top_high = top_high + 32'd1;
					end
					seq = {top_high, it.rx_low};
				end
				if (!ok) begin
					r.status = (it.rx_low == 0) ? arw_pkg::ST_ZERO_SEQ : arw_pkg::ST_EXHAUSTED;
				end else begin
					r.full_sequence = seq;
					offset = win_highest - seq;
					if (win_highest == 0 || seq > win_highest)
						r.status = arw_pkg::ST_ADMISSIBLE;
					else if (offset >= w)
						r.status = arw_pkg::ST_TOO_OLD;
					else if (win_bitmap[offset[5:0]])
						r.status = arw_pkg::ST_DUPLICATE;
					else
						r.status = arw_pkg::ST_ADMISSIBLE;
				end
			end
		end
		arw_pkg::MODE_COMMIT: begin
			seq = it.auth_seq;
			if (w == 0 || seq == 0 || (!cfg_ext && seq[63:32] != 0)) begin
				r.accepted = 1'b0;
			end else if (win_highest == 0) begin
				win_highest = seq;
				win_bitmap  = 64'd1;
				r.accepted  = 1'b1;
			end else if (seq > win_highest) begin
				// Slide the window forward
				adv = seq - win_highest;
				win_bitmap  = (adv >= w) ? 64'd1 : ((win_bitmap << adv[5:0]) | 64'd1);
				win_bitmap  = win_bitmap & low_ones(w);
				win_highest = seq;
				r.accepted  = 1'b1;
			end else begin
				// Mark a late arrival inside the window
				offset = win_highest - seq;
				if (offset >= w || win_bitmap[offset[5:0]]) begin
					r.accepted = 1'b0;
				end else begin
					win_bitmap[offset[5:0]] = 1'b1;
					r.accepted = 1'b1;
				end
			end
		end
		arw_pkg::MODE_RESTORE: begin
			if (w == 0 || (!cfg_ext && it.restore_highest[63:32] != 0) ||
			    (it.restore_bitmap & ~low_ones(w)) != 0 ||
			    ((it.restore_highest == 0) != (it.restore_bitmap == 0)) ||
			    (it.restore_highest != 0 && !it.restore_bitmap[0])) begin
				r.accepted = 1'b0;
			end else begin
				win_highest = it.restore_highest;
				win_bitmap  = it.restore_bitmap;
				r.accepted  = 1'b1;
			end
		end
		default: begin
			r = '0;
		end
		endcase
		return r;
	endfunction

	// Queue one word; fields the mode does not use carry random bits
	task automatic queue_item(input logic [arw_pkg::MODE_W-1:0] mode,
		input logic [arw_pkg::SEQ_W-1:0] a, input logic [arw_pkg::SEQ_W-1:0] b);
		replay_item_t it;
		it.mode            = mode;
		it.rx_low          = $urandom;
		it.auth_seq        = {$urandom, $urandom};
		it.restore_highest = {$urandom, $urandom};
		it.restore_bitmap  = {$urandom, $urandom};
		case (mode)
		arw_pkg::MODE_CHECK:   it.rx_low = a[31:0];
		arw_pkg::MODE_COMMIT:  it.auth_seq = a;
		arw_pkg::MODE_RESTORE: begin
			it.restore_highest = a;
			it.restore_bitmap  = b;
		end
		default: ;
		endcase
		pending_items.push_back(it);
	endtask

	// Queue random traffic that mostly walks around a moving window edge
	task automatic queue_random(input int count, input int w, input bit ext);
		logic [arw_pkg::SEQ_W-1:0]        base, seq, top, bits;
		logic signed [arw_pkg::SEQ_W-1:0] step;
		int                               eff, span, pick, delta;
		eff  = (w > arw_pkg::MAX_WINDOW) ? 0 : w;
		span = (eff == 0) ? 8 : eff;
		base = 64'(1 + $urandom_range(0, 300));
		case ($urandom_range(0, 3))
		1:       base[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 2 * span);
		2:       base[31:0] = $urandom;
		default: ;
		endcase
		if (ext) begin
			case ($urandom_range(0, 3))
			0:       base[63:32] = 32'd0;
			1:       base[63:32] = 32'd1;
			2:       base[63:32] = $urandom;
			default: base[63:32] = 32'hFFFF_FFFF;
			endcase
		end
		if (base == 0)
			base = 64'd1;
		// Plant the window where the traffic will run
		queue_item(arw_pkg::MODE_RESTORE, base, 64'd1);
		for (int i = 0; i < count; i++) begin
			pick  = $urandom_range(0, 99);
			delta = $urandom_range(0, 2 * span + 8) - (span + 4);
			step  = 64'(delta);
			seq   = base + step;
			if (pick < 40) begin
				if (pick < 6)
					seq = base + 64'($urandom_range(span, 3 * span + 100));
				queue_item(arw_pkg::MODE_COMMIT, seq, '0);
				if (seq != 0 && seq > base && (ext || seq[63:32] == 0))
					base = seq;
			end else if (pick < 75) begin
				if (pick < 43)
					seq = '0;
				else if (pick < 47)
					seq = 64'($urandom);
				queue_item(arw_pkg::MODE_CHECK, seq, '0);
			end else if (pick < 85) begin
				top = (pick < 77) ? {$urandom, $urandom} : seq;
				if (pick < 83) begin
					bits = ({$urandom, $urandom} & low_ones(64'(eff))) | 64'(top != 0);
					if (top != 0 && (ext || top[63:32] == 0))
						base = top;
				end else if (pick == 84) begin
					top  = '0;
					bits = '0;
				end else begin
					bits = {$urandom, $urandom};
				end
				queue_item(arw_pkg::MODE_RESTORE, top, bits);
			end else if (pick < 90) begin
				queue_item(MODE_UNUSED, '0, '0);
			end else if (pick < 95) begin
				queue_item(arw_pkg::MODE_COMMIT, {$urandom, $urandom}, '0);
			end else begin
				queue_item(arw_pkg::MODE_CHECK, 64'($urandom), '0);
			end
		end
	endtask

	// Write one register and track it in the predictor
	task automatic write_register(input logic [arw_pkg::CFG_IDX_W-1:0] idx,
		input logic [arw_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == arw_pkg::CFG_WINDOW_WIDTH)
			cfg_width = value[arw_pkg::WIDTH_W-1:0];
		else if (idx == arw_pkg::CFG_EXTENDED_MODE)
			cfg_ext = value[0];
	endtask

	// Hold until every queued word has gone in and its verdict has come out
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_ch.valid || predicted_verdicts.size() != 0);
	endtask

	// Stimulus and phase sequencing
	initial begin
		arst_n                = 1'b0;
		in_ch.valid           = 1'b0;
		in_ch.mode            = '0;
		in_ch.rx_low          = '0;
		in_ch.auth_seq        = '0;
		in_ch.restore_highest = '0;
		in_ch.restore_bitmap  = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = '0;
		cfg_ch.data           = '0;
		out_ch.ready          = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: plain 32-bit numbers, full window
		queue_item(arw_pkg::MODE_CHECK, 64'd0, '0);
		queue_item(arw_pkg::MODE_CHECK, 64'd5, '0);
		queue_item(arw_pkg::MODE_COMMIT, 64'd0, '0);
		queue_item(arw_pkg::MODE_COMMIT, 64'h1_0000_0000, '0);
		queue_item(arw_pkg::MODE_COMMIT, 64'd100, '0);
		queue_item(arw_pkg::MODE_COMMIT, 64'd100, '0);
		queue_item(arw_pkg::MODE_CHECK, 64'd100, '0);
		queue_item(arw_pkg::MODE_CHECK, 64'd36, '0);
		queue_item(arw_pkg::MODE_COMMIT, 64'd37, '0);
		queue_item(arw_pkg::MODE_COMMIT, 64'hFFFF_FFFF, '0);
		queue_item(arw_pkg::MODE_RESTORE, 64'd0, 64'd0);
		queue_item(arw_pkg::MODE_RESTORE, 64'd10, 64'd0);
		queue_item(arw_pkg::MODE_RESTORE, 64'd10, 64'd2);
		queue_item(arw_pkg::MODE_RESTORE, '1, '1);
		queue_item(MODE_UNUSED, '0, '0);
		queue_random(150, int'(cfg_width), cfg_ext);
		wait_idle();

		// Extended numbers: epoch wrap in both directions, exhaustion at the ends
		write_register(arw_pkg::CFG_WINDOW_WIDTH, 8'd64);
		write_register(arw_pkg::CFG_EXTENDED_MODE, 8'd1);
		queue_item(arw_pkg::MODE_RESTORE, 64'h1_0000_0010, 64'd1);
		queue_item(arw_pkg::MODE_CHECK, 64'hFFFF_FFF0, '0);
		queue_item(arw_pkg::MODE_CHECK, 64'd0, '0);
		queue_item(arw_pkg::MODE_RESTORE, 64'h10, 64'd1);
		queue_item(arw_pkg::MODE_CHECK, 64'hFFFF_FFF0, '0);
		queue_item(arw_pkg::MODE_RESTORE, 64'hFFFF_FFFF_FFFF_FFF0, '1);
		queue_item(arw_pkg::MODE_CHECK, 64'd5, '0);
		queue_item(arw_pkg::MODE_CHECK, 64'd0, '0);
		queue_item(arw_pkg::MODE_COMMIT, '1, '0);
		queue_random(200, int'(cfg_width), cfg_ext);
		// Stall the result side while words keep coming
		hold_token = hold_token + 1;
		wait_idle();

		// Narrowest window, then disabled and oversized widths
		write_register(arw_pkg::CFG_WINDOW_WIDTH, 8'd1);
		write_register(arw_pkg::CFG_EXTENDED_MODE, 8'hFE);
		queue_random(150, int'(cfg_width), cfg_ext);
		wait_idle();
		write_register(arw_pkg::CFG_EXTENDED_MODE, 8'd1);
		queue_random(150, int'(cfg_width), cfg_ext);
		wait_idle();
		write_register(arw_pkg::CFG_WINDOW_WIDTH, 8'd0);
		queue_random(60, int'(cfg_width), cfg_ext);
		wait_idle();
		write_register(arw_pkg::CFG_WINDOW_WIDTH, 8'hFF);
		write_register(arw_pkg::CFG_EXTENDED_MODE, 8'd0);
		queue_random(60, int'(cfg_width), cfg_ext);
		wait_idle();
		write_register(arw_pkg::CFG_WINDOW_WIDTH, 8'd65);
		write_register(arw_pkg::CFG_EXTENDED_MODE, 8'h01);
		queue_random(40, int'(cfg_width), cfg_ext);
		wait_idle();
		write_register(CFG_UNUSED, 8'($urandom));

		// Random settings
		for (int p = 0; p < 4; p++) begin
			write_register(arw_pkg::CFG_WINDOW_WIDTH,
				8'($urandom_range(1, arw_pkg::MAX_WINDOW)));
			write_register(arw_pkg::CFG_EXTENDED_MODE, 8'($urandom_range(0, 255)));
			queue_random(200, int'(cfg_width), cfg_ext);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Driver: offer words in bursts, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predicted_verdicts.push_back(advance_window(offered));
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					if (gap_left > 0)
						gap_left = gap_left - 1;
					in_ch.valid <= 1'b0;
				end else begin
					offered = pending_items.pop_front();
					in_ch.valid           <= 1'b1;
					in_ch.mode            <= offered.mode;
					in_ch.rx_low          <= offered.rx_low;
					in_ch.auth_seq        <= offered.auth_seq;
					in_ch.restore_highest <= offered.restore_highest;
					in_ch.restore_bitmap  <= offered.restore_bitmap;
					burst_left = burst_left - 1;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
						gap_left   = $urandom_range(0, 6);
					end
				end
			end
		end
	end

	// Long receiver hold-off, started by the sequencing block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: stall on a rotating pattern and check each result word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_verdicts.size() == 0) begin
					$error("result word with no verdict pending");
					mismatches = mismatches + 1;
				end else begin
					want = predicted_verdicts.pop_front();
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						mismatches = mismatches + 1;
					end
					if (out_ch.full_sequence !== want.full_sequence) begin
						$error("full_sequence: expected %0h, got %0h",
							want.full_sequence, out_ch.full_sequence);
						mismatches = mismatches + 1;
					end
					if (out_ch.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, out_ch.accepted);
						mismatches = mismatches + 1;
					end
				end
			end
			out_ch.ready <= (hold_left == 0) && stall_pattern[0];
			// Rotate the pattern, reload it now and then
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(16, 96);
				stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF :
					(16'($urandom) | 16'h0101);
			end else begin
				pattern_age = pattern_age - 1;
				stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
`default_nettype wire
